// ===== design/assert_macros.svh =====
// Assertion macros used by the framer's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cpf_pkg.sv =====
// Types, constants and helper functions of the CRC_A parity frame packer.
`timescale 1ns / 1ps

package cpf_pkg;

	localparam logic [15:0] CRC_A_INIT = 16'h6363;
	localparam logic [15:0] CRC_A_POLY = 16'h8408;
	localparam logic [5:0]  CHAR_BITS  = 6'd9;
	localparam logic [5:0]  CHAR3_BITS = 6'd27;
	localparam int          OUT_BYTES_MAX = 5;

	// Up to five output bytes produced by one input beat.
	typedef struct packed {
		logic [8*OUT_BYTES_MAX-1:0] bits;
		logic [2:0]                 count;
		logic                       last;
		logic [11:0]                total;
	} pack_t;

	function automatic logic odd_parity(input logic [7:0] b);
		return ~(^b);
	endfunction

	// Reflected CRC_A update over one byte, LSB first.
	function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_A_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== design/cpf_packer.sv =====
// Frame state and the single-pass packing of one byte into output bits.
`timescale 1ns / 1ps

module cpf_packer #(
	parameter logic [11:0] BITS_LIMIT = 12'd2322
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            auto_mode,
	input  logic [7:0]      data_byte,
	input  logic            parity_bit,
	input  logic            last_byte,
	output cpf_pkg::pack_t  pack
);
	import cpf_pkg::*;

	logic [15:0] crc_q;
	logic [6:0]  accum_q;
	logic [2:0]  resid_q;
	logic [11:0] total_q;

	logic [15:0] crc_next;
	logic [8:0]  ch0, ch1, ch2;
	logic        append;
	logic [33:0] stream;
	logic [5:0]  nbits;
	logic [2:0]  nfull;
	logic [2:0]  rem;
	logic [12:0] total_sum;
	logic [11:0] total_sat;
	logic [6:0]  accum_next;

	always_comb begin
		crc_next = crc_a_byte(crc_q, data_byte);
		ch0 = {(auto_mode ? odd_parity(data_byte) : parity_bit), data_byte};
		ch1 = {odd_parity(crc_next[7:0]), crc_next[7:0]};
		ch2 = {odd_parity(crc_next[15:8]), crc_next[15:8]};
		append = last_byte && auto_mode;

		stream = {27'd0, accum_q} | (34'(ch0) << resid_q);
		if (append) begin
			stream = stream | (34'(ch1) << (5'(resid_q) + 5'd9))
				| (34'(ch2) << (5'(resid_q) + 5'd18));
		end

		nbits = {3'd0, resid_q} + (append ? CHAR3_BITS : CHAR_BITS);
		nfull = nbits[5:3];
		rem   = nbits[2:0];

		total_sum = {1'b0, total_q} + {7'd0, (append ? CHAR3_BITS : CHAR_BITS)};
		total_sat = (total_sum > {1'b0, BITS_LIMIT}) ? BITS_LIMIT : total_sum[11:0];

		// Outside the last beat one or two bytes leave; the rest stays as residue.
		accum_next = (nfull == 3'd2) ? stream[22:16] : stream[14:8];

		pack.bits  = {6'd0, stream};
		pack.count = (last_byte && rem != 3'd0) ? nfull + 3'd1 : nfull;
		pack.last  = last_byte;
		pack.total = total_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_A_INIT;
			accum_q <= '0;
			resid_q <= '0;
			total_q <= '0;
		end else if (load) begin
			if (last_byte) begin
				crc_q   <= CRC_A_INIT;
				accum_q <= '0;
				resid_q <= '0;
				total_q <= '0;
			end else begin
				crc_q   <= crc_next;
				accum_q <= accum_next;
				resid_q <= rem;
				total_q <= total_sat;
			end
		end
	end

endmodule

// ===== design/cpf_serializer.sv =====
// Output buffer that hands out the packed bytes of one beat, one per cycle while out_ready is high.
`timescale 1ns / 1ps

module cpf_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  cpf_pkg::pack_t  pack,
	output logic            free,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last,
	output logic [11:0]     frame_bits
);
	import cpf_pkg::*;

	logic [8*OUT_BYTES_MAX-1:0] buf_q;
	logic [2:0]                 cnt_q;
	logic                       last_q;
	logic [11:0]                total_q;

	assign out_valid  = (cnt_q != 3'd0);
	assign out_byte   = buf_q[7:0];
	assign out_last   = last_q && (cnt_q == 3'd1);
	assign frame_bits = out_last ? total_q : 12'd0;
	// The buffer can take a new load when it is empty or its final byte leaves now.
	assign free = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pack.count;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q   <= pack.bits;
			last_q  <= pack.last;
			total_q <= pack.total;
		end else if (out_valid && out_ready) begin
			buf_q <= buf_q >> 8;
		end
	end

endmodule

// ===== design/crc_a_parity_frame_packer.sv =====
// Top level of the CRC_A parity frame packer: input stage, packer and output buffer.
// Path: an accepted beat is registered in the input stage, then loaded into the output buffer.
// Throughput: one input beat per cycle while each beat yields one byte and out_ready
// stays high; a beat's bytes (one to five) hold the output buffer until the last one leaves.
// Reset: arst_n clears the frame state to CRC 0x6363, no residue, zero bit count,
// empties both stages and sets auto_mode to 1.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc_a_parity_frame_packer #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        parity_bit,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [11:0] frame_bits
);
	import cpf_pkg::*;

	localparam logic [11:0] BitsLimit = 12'((MAX_FRAME_BYTES + 2) * 9);

	logic       auto_mode_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       par_s1;
	logic       last_s1;
	logic       load;
	logic       free;
	pack_t      pack;

	assign cfg_ready = 1'b1;
	assign load      = valid_s1 && free;
	assign in_ready  = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			auto_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			par_s1  <= parity_bit;
			last_s1 <= last_byte;
		end
	end

	cpf_packer #(
		.BITS_LIMIT(BitsLimit)
	) u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.auto_mode(auto_mode_q),
		.data_byte(data_s1),
		.parity_bit(par_s1),
		.last_byte(last_s1),
		.pack(pack)
	);

	cpf_serializer u_serializer (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.pack(pack),
		.free(free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_last(out_last),
		.frame_bits(frame_bits)
	);

	`ASSERT_NEXT(a_load_fills_buffer, clk, arst_n, load, out_valid, "load left the output buffer empty")
	`ASSERT_IMPL(a_last_has_bits, clk, arst_n, out_valid && out_last, frame_bits != 12'd0, "final beat carries no bit count")
	`ASSERT_IMPL(a_bits_only_on_last, clk, arst_n, out_valid && !out_last, frame_bits == 12'd0, "bit count on a non-final beat")
	`ASSERT_IMPL(a_empty_stage_ready, clk, arst_n, !valid_s1, in_ready, "empty input stage refuses a beat")

endmodule

// ===== bench/crc_a_parity_frame_packer_tb.sv =====
// Self-checking bench for the CRC_A parity frame packer: directed frames, then random frames.
`timescale 1ns / 1ps

module crc_a_parity_frame_packer_tb;

	localparam int MAX_FRAME_BYTES = 256;
	localparam int BITS_CAP        = (MAX_FRAME_BYTES + 2) * 9;
	localparam logic [15:0] CRC_SEED = 16'h6363;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic MODE_RAW  = 1'b0;
	localparam logic MODE_AUTO = 1'b1;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 190;
	localparam int MAX_GAP       = 10;

	typedef struct {
		logic [7:0]  data;
		logic        last;
		logic [11:0] total;
	} packed_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        parity_bit;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        out_last;
	logic [11:0] frame_bits;

	// Mirror of the framer state and its mode register.
	logic [15:0] crc_state;
	logic [15:0] acc_state;
	logic [2:0]  res_state;
	logic [11:0] total_state;
	logic        mode_mirror;

	packed_byte_t pending_bytes[$];
	int           mismatches;
	bit           no_idle;

	crc_a_parity_frame_packer #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.parity_bit(parity_bit),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.frame_bits(frame_bits)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic odd_bit(input logic [7:0] b);
		return (^b) ^ 1'b1;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic clear_frame_state();
		crc_state   = CRC_SEED;
		acc_state   = 16'h0000;
		res_state   = 3'd0;
		total_state = 12'd0;
	endtask

	task automatic crc_advance(input logic [7:0] d);
		logic [15:0] c;
		int i;
		c = crc_state ^ {8'h00, d};
		for (i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		crc_state = c;
	endtask

	// Appends one 9-bit character and queues every output byte it completes.
	task automatic pack_char(input logic [7:0] d, input logic p);
		logic [31:0] wide;
		int fill;
		int t;
		wide = {16'h0000, acc_state} | ({23'd0, p, d} << res_state);
		fill = res_state + 9;
		t = total_state + 9;
		if (t > BITS_CAP) begin
			t = BITS_CAP;
		end
		total_state = t[11:0];
		while (fill >= 8) begin
			pending_bytes.push_back('{data: wide[7:0], last: 1'b0, total: 12'd0});
			wide = wide >> 8;
			fill -= 8;
		end
		acc_state = wide[15:0];
		res_state = fill[2:0];
	endtask

	task automatic predict_beat(input logic [7:0] d, input logic p, input logic l);
		logic [7:0] lo;
		logic [7:0] hi;
		packed_byte_t tail;
		crc_advance(d);
		pack_char(d, mode_mirror ? odd_bit(d) : p);
		if (l) begin
			if (mode_mirror) begin
				lo = crc_state[7:0];
				hi = crc_state[15:8];
				pack_char(lo, odd_bit(lo));
				pack_char(hi, odd_bit(hi));
			end
			if (res_state != 3'd0) begin
				pending_bytes.push_back('{data: acc_state[7:0], last: 1'b0, total: 12'd0});
			end
			tail = pending_bytes.pop_back();
			tail.last  = 1'b1;
			tail.total = total_state;
			pending_bytes.push_back(tail);
			clear_frame_state();
		end
	endtask

	task automatic send_byte(input logic [7:0] d, input logic p, input logic l);
		int gap;
		gap = draw_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid   = 1'b1;
		data_byte  = d;
		parity_bit = p;
		last_byte  = l;
		do @(posedge clk); while (!in_ready);
		predict_beat(d, p, l);
	endtask

	// Lowers valid and lets every queued byte come out before the block is touched again.
	task automatic wait_outputs_done();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		in_valid  = 1'b0;
		cfg_valid = 1'b1;
		cfg_data  = m;
		do @(posedge clk); while (!cfg_ready);
		mode_mirror = m;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic report(input string field, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Receiver: after each accepted beat, ready drops for a freshly drawn number of cycles, possibly none.
	initial begin : receiver
		int gap;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!(arst_n && out_valid && out_ready));
			gap = draw_gap();
			repeat (gap) begin
				@(negedge clk);
				out_ready = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_out
		packed_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected output beat, expected none, actual byte %0d",
					$time, out_byte);
			end else begin
				want = pending_bytes.pop_front();
				report("out_byte", want.data, out_byte);
				report("out_last", want.last, out_last);
				report("frame_bits", want.total, frame_bits);
			end
		end
	end

	task automatic test_reset_default();
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b1);
		wait_outputs_done();
	endtask

	task automatic test_auto_frames();
		write_mode(MODE_AUTO);
		send_byte(8'h50, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		wait_outputs_done();
	endtask

	// Raw parity is taken as given, even where it is not odd.
	task automatic test_raw_frames();
		write_mode(MODE_RAW);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hAA, 1'b1, 1'b1);
		send_byte(8'h55, 1'b0, 1'b1);
		wait_outputs_done();
	endtask

	// Eight raw characters fill exactly nine bytes, so no padding byte follows.
	task automatic test_exact_byte_fill();
		int i;
		for (i = 0; i < 8; i++) begin
			send_byte(8'($urandom_range(0, 255)), i[0], i == 7);
		end
		wait_outputs_done();
	endtask

	task automatic test_mode_switch_midframe();
		write_mode(MODE_AUTO);
		send_byte(8'h93, 1'b0, 1'b0);
		send_byte(8'h70, 1'b0, 1'b0);
		wait_outputs_done();
		write_mode(MODE_RAW);
		send_byte(8'h12, 1'b1, 1'b1);
		wait_outputs_done();
		send_byte(8'h30, 1'b1, 1'b0);
		send_byte(8'h08, 1'b0, 1'b0);
		wait_outputs_done();
		write_mode(MODE_AUTO);
		send_byte(8'hC7, 1'b1, 1'b1);
		wait_outputs_done();
	endtask

	// A frame one byte past the size limit, so the bit count saturates.
	task automatic test_overlong_frame();
		int i;
		no_idle = 1'b1;
		for (i = 0; i <= MAX_FRAME_BYTES; i++) begin
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				i == MAX_FRAME_BYTES);
		end
		wait_outputs_done();
		no_idle = 1'b0;
	endtask

	task automatic test_random_frames();
		int sent;
		int len;
		int flip_at;
		int i;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 1) begin
				write_mode(1'($urandom_range(0, 1)));
			end
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			flip_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : 0;
			for (i = 1; i <= len; i++) begin
				if (i == flip_at) begin
					wait_outputs_done();
					write_mode(!mode_mirror);
				end
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), i == len);
				sent++;
			end
			wait_outputs_done();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		in_valid    = 1'b0;
		data_byte   = 8'h00;
		parity_bit  = 1'b0;
		last_byte   = 1'b0;
		no_idle     = 1'b0;
		mismatches  = 0;
		mode_mirror = MODE_AUTO;
		clear_frame_state();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_reset_default();
		test_auto_frames();
		test_raw_frames();
		test_exact_byte_fill();
		test_mode_switch_midframe();
		test_overlong_frame();
		test_random_frames();
		wait_outputs_done();

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/cpf_pkg.sv
design/cpf_packer.sv
design/cpf_serializer.sv
design/crc_a_parity_frame_packer.sv
bench/crc_a_parity_frame_packer_tb.sv
